@@ sv/tnsc_pkg.sv @@
// package for the trace node stream checker
// holds parse phases, class and error codes and field widths; no dependencies
package tnsc_pkg;

    localparam int StringLimit = 30;
    localparam int NClass      = 11;

    typedef enum logic [4:0] {
        PH_HSTR, PH_HPTR, PH_TAG, PH_SKIP, PH_ARITY, PH_MD1, PH_MD2, PH_IDSTR,
        PH_CSTR, PH_ICNT, PH_IWORDS, PH_RCNT1, PH_RWORDS1, PH_RCNT2, PH_RWORDS2,
        PH_DONE, PH_HALT
    } t_phase;

    localparam logic [3:0] CLASS_MD  = 4'd7;
    localparam logic [3:0] CLASS_NT  = 4'd8;
    localparam logic [3:0] CLASS_SR  = 4'd9;
    localparam logic [3:0] CLASS_HDR = 4'd10;

    localparam logic [2:0] ERR_OK    = 3'd0;
    localparam logic [2:0] ERR_TAG   = 3'd1;
    localparam logic [2:0] ERR_TR    = 3'd2;
    localparam logic [2:0] ERR_MD    = 3'd3;
    localparam logic [2:0] ERR_NT    = 3'd4;
    localparam logic [2:0] ERR_TRUNC = 3'd5;

    typedef struct packed {
        logic        emit;
        logic [3:0]  cls;
        logic [31:0] off;
        logic [31:0] len;
        logic [2:0]  err;
    } t_event;

    typedef struct packed {
        logic [3:0]  node_class;
        logic [31:0] node_offset;
        logic [15:0] node_length;
        logic [31:0] class_count;
        logic [31:0] class_bytes;
        logic [2:0]  error_code;
    } t_record;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ sv/trace_node_stream_checker.sv @@
// a node record is registered in the result register, or in the skid word while the output is stalled
// throughput: one byte per cycle; tready drops only while the skid word is full
// synchronous active-low reset clears the parser, class totals and output
// top level of the trace node stream checker
// depends on tnsc_pkg, tnsc_parser, tnsc_tally
module trace_node_stream_checker #(
    parameter int STRING_LIMIT = tnsc_pkg::StringLimit
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // data_byte
    input  logic         s_axis_tlast,  // stream_end
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // node_class, node_offset, node_length, class_count, class_bytes, error_code
    output logic [119:0] m_axis_tdata
);
    tnsc_pkg::t_event  evt;
    tnsc_pkg::t_record rec;
    logic room, halted, take;

    assign s_axis_tready = room;
    assign take = s_axis_tvalid && room;

    tnsc_parser #(.STRING_LIMIT(STRING_LIMIT)) u_parser (
        .i_clk, .i_rst_n, .i_take(take), .i_byte(s_axis_tdata), .i_end(s_axis_tlast),
        .o_halted(halted), .o_evt(evt)
    );

    tnsc_tally u_tally (
        .i_clk, .i_rst_n, .i_load(take && !halted), .i_evt(evt), .i_ready(m_axis_tready),
        .o_valid(m_axis_tvalid), .o_room(room), .o_rec(rec)
    );

    assign m_axis_tdata = {1'b0, rec.error_code, rec.class_bytes, rec.class_count,
                           rec.node_length, rec.node_offset, rec.node_class};
endmodule

@@ sv/tnsc_parser.sv @@
// byte parser: phase machine that finds node boundaries and errors
// depends on tnsc_pkg
module tnsc_parser #(
    parameter int STRING_LIMIT = tnsc_pkg::StringLimit
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  logic             i_end,
    output logic             o_halted,
    output tnsc_pkg::t_event o_evt
);
    localparam int SW = $clog2(STRING_LIMIT + 1);
    localparam logic [SW-1:0] SLim = SW'(STRING_LIMIT);

    tnsc_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_cls, n_cls;
    logic [10:0] r_left, n_left;
    logic [SW-1:0] r_chars, n_chars;
    logic [7:0]  r_words, n_words;
    logic [31:0] r_off, r_start, n_start;
    logic [2:0]  r_err, n_err;

    assign o_halted = (r_phase == tnsc_pkg::PH_DONE) || (r_phase == tnsc_pkg::PH_HALT);

    always_comb begin
        logic [SW-1:0] c1;
        logic          sdone, done, wdone;
        logic [10:0]   lm;
        logic [2:0]    kind;
        logic [4:0]    sub;
        logic [2:0]    err;
        n_phase = r_phase; n_cls = r_cls; n_left = r_left; n_chars = r_chars;
        n_words = r_words; n_start = r_start; n_err = r_err;
        err = tnsc_pkg::ERR_OK; done = 1'b0;
        kind = i_byte[7:5]; sub = i_byte[4:0];
        c1 = r_chars + SW'(1);
        sdone = (i_byte == 8'd0) || (c1 >= SLim);
        lm = (r_left != 11'd0) ? r_left - 11'd1 : 11'd0;
        wdone = 1'b0;
        o_evt = '0;
        if (r_phase inside {tnsc_pkg::PH_HSTR, tnsc_pkg::PH_MD1, tnsc_pkg::PH_MD2,
                            tnsc_pkg::PH_IDSTR, tnsc_pkg::PH_CSTR})
            n_chars = sdone ? '0 : c1;
        if (r_phase inside {tnsc_pkg::PH_IWORDS, tnsc_pkg::PH_RWORDS1,
                            tnsc_pkg::PH_RWORDS2}) begin
            n_left = lm;
            if (lm == 11'd0) begin
                n_words = (r_words != 8'd0) ? r_words - 8'd1 : 8'd0;
                if (n_words == 8'd0) wdone = 1'b1;
                else n_left = 11'd4;
            end
        end
        unique case (r_phase)
            tnsc_pkg::PH_HSTR: begin
                n_cls = tnsc_pkg::CLASS_HDR; n_start = '0;
                if (sdone) begin n_phase = tnsc_pkg::PH_HPTR; n_left = 11'd8; end
            end
            tnsc_pkg::PH_HPTR, tnsc_pkg::PH_SKIP: begin
                n_left = lm; done = (lm == 11'd0);
            end
            tnsc_pkg::PH_TAG: begin
                n_start = r_off; n_chars = '0;
                if (kind > 3'd3) begin
                    err = tnsc_pkg::ERR_TAG; n_cls = 4'd0;
                end else if (kind == 3'd0) begin
                    n_cls = 4'd0;
                    if (sub > 5'd6) err = tnsc_pkg::ERR_TR;
                    else begin
                        n_cls = sub[3:0];
                        if (sub == 5'd0) n_phase = tnsc_pkg::PH_ARITY;
                        else begin
                            n_phase = tnsc_pkg::PH_SKIP;
                            n_left = (sub == 5'd1) ? 11'd12 : (sub == 5'd2) ? 11'd8 : 11'd4;
                        end
                    end
                end else if (kind == 3'd1) begin
                    n_cls = tnsc_pkg::CLASS_MD;
                    if (sub > 5'd1) err = tnsc_pkg::ERR_MD;
                    else n_phase = tnsc_pkg::PH_MD1;
                end else if (kind == 3'd2) begin
                    n_cls = tnsc_pkg::CLASS_NT;
                    priority case (sub)
                        5'd0, 5'd4: begin n_phase = tnsc_pkg::PH_SKIP; n_left = 11'd4; end
                        5'd1: begin n_phase = tnsc_pkg::PH_SKIP; n_left = 11'd1; end
                        5'd5: begin n_phase = tnsc_pkg::PH_SKIP; n_left = 11'd8; end
                        5'd2: n_phase = tnsc_pkg::PH_ICNT;
                        5'd3: n_phase = tnsc_pkg::PH_RCNT1;
                        5'd6, 5'd7: n_phase = tnsc_pkg::PH_IDSTR;
                        5'd13: n_phase = tnsc_pkg::PH_CSTR;
                        5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14, 5'd15, 5'd16: done = 1'b1;
                        default: err = tnsc_pkg::ERR_NT;
                    endcase
                end else begin
                    n_cls = tnsc_pkg::CLASS_SR;
                    n_phase = tnsc_pkg::PH_SKIP; n_left = 11'd8;
                end
            end
            tnsc_pkg::PH_ARITY: begin
                n_left = 11'(({3'd0, i_byte} + 11'd3) << 2);
                n_phase = tnsc_pkg::PH_SKIP;
            end
            tnsc_pkg::PH_MD1: if (sdone) n_phase = tnsc_pkg::PH_MD2;
            tnsc_pkg::PH_MD2, tnsc_pkg::PH_CSTR: done = sdone;
            tnsc_pkg::PH_IDSTR:
                if (sdone) begin n_phase = tnsc_pkg::PH_SKIP; n_left = 11'd9; end
            tnsc_pkg::PH_ICNT, tnsc_pkg::PH_RCNT1, tnsc_pkg::PH_RCNT2: begin
                n_words = i_byte;
                if (i_byte == 8'd0) begin
                    if (r_phase == tnsc_pkg::PH_RCNT1) n_phase = tnsc_pkg::PH_RCNT2;
                    else done = 1'b1;
                end else begin
                    n_left = 11'd4;
                    n_phase = (r_phase == tnsc_pkg::PH_ICNT) ? tnsc_pkg::PH_IWORDS :
                              (r_phase == tnsc_pkg::PH_RCNT1) ? tnsc_pkg::PH_RWORDS1 :
                              tnsc_pkg::PH_RWORDS2;
                end
            end
            tnsc_pkg::PH_IWORDS, tnsc_pkg::PH_RWORDS2: done = wdone;
            tnsc_pkg::PH_RWORDS1: if (wdone) n_phase = tnsc_pkg::PH_RCNT2;
            default: ;
        endcase
        if (n_cls > 4'd10) n_cls = 4'd0;
        o_evt.off = n_start;
        o_evt.len = r_off + 32'd1 - n_start;
        o_evt.cls = n_cls;
        if (err != tnsc_pkg::ERR_OK) begin
            n_err = err; n_phase = tnsc_pkg::PH_HALT;
            o_evt.emit = 1'b1; o_evt.err = err; o_evt.off = r_off; o_evt.len = 32'd1;
            o_evt.cls = (err == tnsc_pkg::ERR_MD) ? tnsc_pkg::CLASS_MD :
                        (err == tnsc_pkg::ERR_NT) ? tnsc_pkg::CLASS_NT : 4'd0;
        end else if (done) begin
            o_evt.emit = 1'b1;
            n_phase = i_end ? tnsc_pkg::PH_DONE : tnsc_pkg::PH_TAG;
        end else if (i_end) begin
            o_evt.emit = 1'b1; o_evt.err = tnsc_pkg::ERR_TRUNC;
            n_err = tnsc_pkg::ERR_TRUNC; n_phase = tnsc_pkg::PH_HALT;
        end
        if (o_halted) o_evt.emit = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tnsc_pkg::PH_HSTR; r_cls <= '0; r_left <= '0; r_chars <= '0;
            r_words <= '0; r_off <= '0; r_start <= '0; r_err <= '0;
        end else if (i_take && !o_halted) begin
            r_phase <= n_phase; r_cls <= n_cls; r_left <= n_left; r_chars <= n_chars;
            r_words <= n_words; r_off <= r_off + 32'd1; r_start <= n_start; r_err <= n_err;
        end
    end
endmodule

@@ sv/tnsc_tally.sv @@
// per-class count and byte totals, result register with one-entry skid
// depends on tnsc_pkg
module tnsc_tally (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tnsc_pkg::t_event  i_evt,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_room,
    output tnsc_pkg::t_record o_rec
);
    logic [31:0] r_cnt [tnsc_pkg::NClass];
    logic [31:0] r_byt [tnsc_pkg::NClass];
    logic        r_v, r_sv;
    tnsc_pkg::t_record r_rec, r_skid, n_rec;
    logic [31:0] c_new, b_new;

    assign o_room  = !r_sv;
    assign o_valid = r_v;
    assign o_rec   = r_rec;

    always_comb begin
        c_new = tnsc_pkg::sat_add(r_cnt[i_evt.cls], 32'd1);
        b_new = tnsc_pkg::sat_add(r_byt[i_evt.cls], i_evt.len);
        n_rec.node_class  = i_evt.cls;
        n_rec.node_offset = i_evt.off;
        n_rec.node_length = (i_evt.len > 32'hFFFF) ? 16'hFFFF : i_evt.len[15:0];
        n_rec.error_code  = i_evt.err;
        if (i_evt.err == tnsc_pkg::ERR_OK) begin
            n_rec.class_count = c_new; n_rec.class_bytes = b_new;
        end else if (i_evt.err == tnsc_pkg::ERR_TRUNC) begin
            n_rec.class_count = r_cnt[i_evt.cls]; n_rec.class_bytes = r_byt[i_evt.cls];
        end else begin
            n_rec.class_count = '0; n_rec.class_bytes = '0;
        end
    end

    logic push;
    assign push = i_load && i_evt.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0; r_sv <= 1'b0;
            for (int k = 0; k < tnsc_pkg::NClass; k++) begin
                r_cnt[k] <= '0; r_byt[k] <= '0;
            end
        end else begin
            if (push && i_evt.err == tnsc_pkg::ERR_OK) begin
                r_cnt[i_evt.cls] <= c_new; r_byt[i_evt.cls] <= b_new;
            end
            if (!r_v || i_ready) begin
                if (r_sv) begin
                    r_rec <= r_skid; r_v <= 1'b1; r_sv <= 1'b0;
                end else begin
                    r_v <= push;
                    if (push) r_rec <= n_rec;
                end
            end else if (push) begin
                r_skid <= n_rec; r_sv <= 1'b1;
            end
        end
    end
endmodule

@@ sv/tnsc_checker.sv @@
// port-level assertions for the trace node stream checker, with bind
// depends on trace_node_stream_checker ports only
module tnsc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[118:116] <= 3'd5)
        else $error("bad error code");
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd10)
        else $error("bad class");
    a_bad_tag_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[118:116] != 3'd0 && m_axis_tdata[118:116] != 3'd5
        |-> m_axis_tdata[51:36] == 16'd1 && m_axis_tdata[115:52] == 64'd0)
        else $error("bad tag record malformed");
    a_ready_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
endmodule

bind trace_node_stream_checker tnsc_checker u_tnsc_checker (
    .i_clk, .i_rst_n, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
